// ===== hw/rtl/obp_pkg.sv =====
package obp_pkg;

  // Fixed point sizes: 65536 stands for 1.0
  localparam int unsigned SIZE_W = 17;
  localparam logic [SIZE_W-1:0] ONE_FIXED = 17'h10000;

  // Register map
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_CAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_LIMIT = 2'd2;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned LIMIT_W = 7;

  // Placement policies; the unused code behaves as best fit
  localparam logic [MODE_W-1:0] FIT_NEXT  = 2'd0;
  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd1;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd2;

  // Commands
  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Result status
  localparam int unsigned STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 2'd2;

  // Output field widths
  localparam int unsigned OUT_IDX_W  = 6;
  localparam int unsigned OUT_OPEN_W = 7;

  // Search token handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic              found;
    logic [SIZE_W-1:0] best;
  } obp_scan_t;

  // Update broadcast from the controller to every cell
  typedef struct packed {
    logic              clr;
    logic              upd;
    logic              fresh;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] cap;
  } obp_wr_t;

endpackage

// ===== hw/rtl/obp_cell.sv =====
module obp_cell #(
  parameter int unsigned IDX      = 0,
  parameter int unsigned IW       = 6,
  parameter int unsigned CW       = 7
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [obp_pkg::MODE_W-1:0] fit_mode_i,
  input  logic [obp_pkg::SIZE_W-1:0] size_i,
  input  logic [CW-1:0]             open_i,
  input  obp_pkg::obp_scan_t        scan_i,
  input  logic [IW-1:0]             chosen_i,
  output obp_pkg::obp_scan_t        scan_o,
  output logic [IW-1:0]             chosen_o,
  input  obp_pkg::obp_wr_t          wr_i,
  input  logic [IW-1:0]             wr_idx_i
);
  import obp_pkg::*;

  localparam logic [CW-1:0] IDX_C  = CW'(IDX);
  localparam logic [CW-1:0] IDX_P1 = CW'(IDX + 1);
  localparam logic [IW-1:0] IDX_I  = IW'(IDX);

  logic [SIZE_W-1:0] room_q;
  obp_scan_t         scan_q;
  logic [IW-1:0]     chosen_q;

  logic              eligible;
  logic              fits;
  logic [SIZE_W-1:0] left;
  logic              take;

  // Decide whether this bin beats what the token carries so far
  always_comb begin
    eligible = (IDX_C < open_i) && ((fit_mode_i != FIT_NEXT) || (IDX_P1 == open_i));
    fits     = room_q >= size_i;
    left     = room_q - size_i;
    case (fit_mode_i)
      FIT_NEXT:  take = eligible && fits;
      FIT_FIRST: take = eligible && fits && !scan_i.found;
      default:   take = eligible && fits && (left < scan_i.best);
    endcase
  end

  // Pass the token on to the neighbour
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q   <= '0;
      chosen_q <= '0;
    end else begin
      scan_q.vld <= scan_i.vld;
      if (take) begin
        scan_q.found <= 1'b1;
        scan_q.best  <= left;
        chosen_q     <= IDX_I;
      end else begin
        scan_q.found <= scan_i.found;
        scan_q.best  <= scan_i.best;
        chosen_q     <= chosen_i;
      end
    end
  end

  // Hold the room of this bin; refill on clear, shrink when chosen
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_q <= ONE_FIXED;
    end else if (wr_i.clr) begin
      room_q <= wr_i.cap;
    end else if (wr_i.upd && (wr_idx_i == IDX_I)) begin
      room_q <= (wr_i.fresh ? wr_i.cap : room_q) - wr_i.size;
    end
  end

  assign scan_o   = scan_q;
  assign chosen_o = chosen_q;

endmodule

// ===== hw/rtl/online_bin_packing.sv =====
// Online bin packer. A place beat finds a bin by next, first or best fit, opening a
// new bin when none is chosen and the bin limit allows, else reporting overflow; it
// returns status, bin index and open bin count. A clear beat empties every bin and
// leaves one open. Bins sit in a row of NUM_BINS cells and a search token walks the
// row one cell per cycle, whatever the policy. One beat is worked on at a time; the
// next beat is taken while the previous result still waits on the output register.
module online_bin_packing #(
  parameter int unsigned NUM_BINS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [16:0] item_size
  input  logic        s_axis_tuser,   // [0] opcode
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [5:0] bin_index, [12:6] bins_open
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  // configuration
  input  logic                            cfg_we_i,
  input  logic [obp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [obp_pkg::SIZE_W-1:0]      cfg_wdata_i
);
  import obp_pkg::*;

  localparam int unsigned IW  = $clog2(NUM_BINS);
  localparam int unsigned CW  = $clog2(NUM_BINS + 1);
  localparam int unsigned LW  = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int unsigned IXW = (IW > OUT_IDX_W) ? IW : OUT_IDX_W;
  localparam int unsigned OXW = (CW > OUT_OPEN_W) ? CW : OUT_OPEN_W;
  localparam logic [LW-1:0] NUM_BINS_L = LW'(NUM_BINS);

  typedef enum logic [1:0] {IDLE, SCAN, DONE} state_e;

  state_e            state_q;
  logic [MODE_W-1:0] fit_mode_q;
  logic [SIZE_W-1:0] bin_cap_q;
  logic [LIMIT_W-1:0] bin_limit_q;
  logic [SIZE_W-1:0] size_q;
  logic [CW-1:0]     open_q;
  logic              launch_q;
  logic              launch_d;
  logic [STATUS_W-1:0] res_status_q;
  logic [IW-1:0]     res_idx_q;
  logic              m_vld_q;
  logic              m_load;
  logic [STATUS_W-1:0] m_status_q;
  logic [OUT_IDX_W-1:0] m_idx_q;
  logic [OUT_OPEN_W-1:0] m_open_q;

  obp_scan_t     scan_w   [NUM_BINS+1];
  logic [IW-1:0] chosen_w [NUM_BINS+1];
  obp_wr_t       wr;
  logic [IW-1:0] wr_idx;

  logic              s_acc;
  logic [SIZE_W-1:0] s_size;
  logic              tail;
  logic [LW-1:0]     lim_raw;
  logic [LW-1:0]     lim_eff;
  logic              lim_hit;
  logic [IXW-1:0]    idx_ext;
  logic [OXW-1:0]    open_ext;

  assign s_axis_tready = (state_q == IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign s_size        = s_axis_tdata[SIZE_W-1:0];
  assign tail          = (state_q == SCAN) && scan_w[NUM_BINS].vld;
  assign launch_d      = s_acc && (s_axis_tuser == OP_PLACE) && (s_size <= bin_cap_q);
  assign m_load        = (state_q == DONE) && (!m_vld_q || m_axis_tready);

  // Clamp the bin limit to between one and the row length
  always_comb begin
    lim_raw = LW'(bin_limit_q);
    if (lim_raw == '0) begin
      lim_eff = LW'(1);
    end else if (lim_raw > NUM_BINS_L) begin
      lim_eff = NUM_BINS_L;
    end else begin
      lim_eff = lim_raw;
    end
    lim_hit = LW'(open_q) >= lim_eff;
  end

  // Broadcast clear and bin updates to the cells
  always_comb begin
    wr.clr   = s_acc && (s_axis_tuser == OP_CLEAR);
    wr.upd   = 1'b0;
    wr.fresh = 1'b0;
    wr.size  = size_q;
    wr.cap   = bin_cap_q;
    wr_idx   = chosen_w[NUM_BINS];
    if (tail) begin
      if (scan_w[NUM_BINS].found) begin
        wr.upd = 1'b1;
      end else if (!lim_hit) begin
        wr.upd   = 1'b1;
        wr.fresh = 1'b1;
        wr_idx   = IW'(open_q);
      end
    end
  end

  // Launch the search token at the head of the row
  assign scan_w[0].vld   = launch_q;
  assign scan_w[0].found = 1'b0;
  assign scan_w[0].best  = bin_cap_q;
  assign chosen_w[0]     = '0;

  for (genvar g = 0; g < NUM_BINS; g++) begin : g_cell
    obp_cell #(
      .IDX      (g),
      .IW       (IW),
      .CW       (CW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .fit_mode_i (fit_mode_q),
      .size_i     (size_q),
      .open_i     (open_q),
      .scan_i     (scan_w[g]),
      .chosen_i   (chosen_w[g]),
      .scan_o     (scan_w[g+1]),
      .chosen_o   (chosen_w[g+1]),
      .wr_i       (wr),
      .wr_idx_i   (wr_idx)
    );
  end

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q  <= FIT_NEXT;
      bin_cap_q   <= ONE_FIXED;
      bin_limit_q <= LIMIT_W'(64);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FIT_MODE:  fit_mode_q  <= cfg_wdata_i[MODE_W-1:0];
        CFG_BIN_CAP:   bin_cap_q   <= cfg_wdata_i;
        CFG_BIN_LIMIT: bin_limit_q <= cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign idx_ext  = IXW'(res_idx_q);
  assign open_ext = OXW'(open_q);

  // Sequence one beat: accept, walk the row, resolve, deliver
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= IDLE;
      open_q       <= CW'(1);
      launch_q     <= 1'b0;
      size_q       <= '0;
      res_status_q <= ST_OK;
      res_idx_q    <= '0;
      m_vld_q      <= 1'b0;
      m_status_q   <= ST_OK;
      m_idx_q      <= '0;
      m_open_q     <= '0;
    end else begin
      launch_q <= launch_d;
      if (m_load) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_vld_q <= 1'b0;
      end
      case (state_q)
        IDLE: begin
          if (s_acc) begin
            size_q    <= s_size;
            res_idx_q <= '0;
            if (s_axis_tuser == OP_CLEAR) begin
              open_q       <= CW'(1);
              res_status_q <= ST_OK;
              state_q      <= DONE;
            end else if (s_size > bin_cap_q) begin
              res_status_q <= ST_TOO_BIG;
              state_q      <= DONE;
            end else begin
              state_q  <= SCAN;
            end
          end
        end
        SCAN: begin
          if (tail) begin
            state_q <= DONE;
            if (scan_w[NUM_BINS].found) begin
              res_status_q <= ST_OK;
              res_idx_q    <= chosen_w[NUM_BINS];
            end else if (lim_hit) begin
              res_status_q <= ST_OVERFLOW;
              res_idx_q    <= '0;
            end else begin
              res_status_q <= ST_OK;
              res_idx_q    <= IW'(open_q);
              open_q       <= open_q + CW'(1);
            end
          end
        end
        DONE: begin
          if (m_load) begin
            m_status_q <= res_status_q;
            m_idx_q    <= idx_ext[OUT_IDX_W-1:0];
            m_open_q   <= open_ext[OUT_OPEN_W-1:0];
            state_q    <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {3'b000, m_open_q, m_idx_q};
  assign m_axis_tuser  = m_status_q;

endmodule
